// ----- hw/rtl/dxt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dxt_pkg: shared types and arithmetic for the block texture decoder
// Request structs, queue entry, stage records and constant-divide helpers.
// ----------------------------------------------------------------------------
package dxt_pkg;

  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int IMAGE_DIM_RESET   = 64;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 13;
  localparam int PIX_W             = 12;
  localparam int QUEUE_DEPTH       = 2;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] color_half;
    logic [63:0] alpha_half;
  } in_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             last_of_block;
    logic             last_of_image;
  } out_t;

  // classified block waiting for the back end
  typedef struct packed {
    logic [63:0]      color_half;
    logic [63:0]      alpha_half;
    fmt_t             fmt;
    logic [PIX_W-1:0] base_x;
    logic [PIX_W-1:0] base_y;
    logic [1:0]       ncm1;
    logic [1:0]       nrm1;
    logic             last_img;
  } job_t;

  // expanded endpoints and alpha numerators
  typedef struct packed {
    job_t             job;
    logic [1:0][7:0]  er;
    logic [1:0][7:0]  eg;
    logic [1:0][7:0]  eb;
    logic             punch;
    logic             agt;
    logic [5:0][10:0] num;
  } pre_t;

  // finished lookup tables for one block
  typedef struct packed {
    job_t            job;
    logic [3:0][7:0] cr;
    logic [3:0][7:0] cg;
    logic [3:0][7:0] cb;
    logic            punch;
    logic [7:0][7:0] atab;
  } blk_t;

  // v*255/31
  function automatic logic [7:0] expand5(logic [4:0] v);
    logic [12:0] x;
    logic [26:0] p;
    begin
      x = {v, 8'b0} - 13'(v);
      p = 27'(x) * 27'(8457);
      return p[25:18];
    end
  endfunction

  // v*255/63
  function automatic logic [7:0] expand6(logic [5:0] v);
    logic [13:0] x;
    logic [30:0] p;
    begin
      x = {v, 8'b0} - 14'(v);
      p = 31'(x) * 31'(16645);
      return p[27:20];
    end
  endfunction

  // x/3 for x up to 765
  function automatic logic [7:0] div3(logic [9:0] x);
    logic [20:0] p;
    begin
      p = 21'(x) * 21'(683);
      return p[18:11];
    end
  endfunction

  // x/7 for x up to 1785
  function automatic logic [7:0] div7(logic [10:0] x);
    logic [22:0] p;
    begin
      p = 23'(x) * 23'(2341);
      return p[21:14];
    end
  endfunction

  // x/5 for x up to 1275
  function automatic logic [7:0] div5(logic [10:0] x);
    logic [22:0] p;
    begin
      p = 23'(x) * 23'(3277);
      return p[21:14];
    end
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dxt_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dxt_front: request intake and block classification
// Holds configuration, tracks the block position and crops edge blocks.
// ----------------------------------------------------------------------------
module dxt_front import dxt_pkg::*; #(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire in_t                   in_data,
  input  wire logic                  q_ready,
  output      logic                  q_push,
  output      job_t                  q_job
);

  localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
  localparam int BW_W   = DIM_W - 1;
  localparam int BLK_L  = $clog2((MAX_DIMENSION + 3) / 4);
  localparam int BLK_W  = (BLK_L > 0) ? BLK_L : 1;
  localparam int CMP_W  = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
  localparam int XW     = (DIM_W + 1 > PIX_W) ? DIM_W + 1 : PIX_W;
  localparam logic [DIM_W-1:0] DIM_RST = (IMAGE_DIM_RESET > MAX_DIMENSION) ?
      DIM_W'(MAX_DIMENSION) : DIM_W'(IMAGE_DIM_RESET);
  localparam logic [BW_W-1:0]  BLK_RST = BW_W'((int'(DIM_RST) + 3) / 4);

  function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_DATA_W-1:0] v);
    logic [CMP_W-1:0] x;
    begin
      x = CMP_W'(v);
      if (x == '0) return DIM_W'(1);
      if (x > CMP_W'(MAX_DIMENSION)) return DIM_W'(MAX_DIMENSION);
      return DIM_W'(x);
    end
  endfunction

  function automatic logic [BW_W-1:0] blocks_of(logic [DIM_W-1:0] d);
    logic [DIM_W:0] s;
    begin
      s = {1'b0, d} + (DIM_W+1)'(3);
      return BW_W'(s >> 2);
    end
  endfunction

  fmt_t             fmt_r;
  logic [DIM_W-1:0] w_r, h_r;
  logic [BW_W-1:0]  bw_r, bh_r;
  logic [BLK_W-1:0] col_r, row_r, col_nxt, row_nxt;

  logic [BW_W-1:0]  c, r, c_inc, r_inc;
  logic             c_end, r_end;
  logic [DIM_W-1:0] rem_x, rem_y;
  logic [XW-1:0]    bx, by;
  logic             accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign q_push   = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_DXT1;
      w_r   <= DIM_RST;
      h_r   <= DIM_RST;
      bw_r  <= BLK_RST;
      bh_r  <= BLK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FORMAT: begin
          case (cfg_data[1:0])
            FMT_DXT3: fmt_r <= FMT_DXT3;
            FMT_DXT5: fmt_r <= FMT_DXT5;
            default:  fmt_r <= FMT_DXT1;
          endcase
        end
        REG_WIDTH: begin
          w_r  <= clamp_dim(cfg_data);
          bw_r <= blocks_of(clamp_dim(cfg_data));
        end
        REG_HEIGHT: begin
          h_r  <= clamp_dim(cfg_data);
          bh_r <= blocks_of(clamp_dim(cfg_data));
        end
        default: ;
      endcase
    end
  end

  // position of this block after pulling stale counters back inside the image
  always_comb begin
    if (BW_W'(col_r) >= bw_r) begin
      c = '0;
      r = BW_W'(row_r) + BW_W'(1);
    end else begin
      c = BW_W'(col_r);
      r = BW_W'(row_r);
    end
    if (r >= bh_r) r = '0;
    c_inc   = c + BW_W'(1);
    r_inc   = r + BW_W'(1);
    c_end   = c_inc >= bw_r;
    r_end   = r_inc >= bh_r;
    col_nxt = c_end ? '0 : c_inc[BLK_W-1:0];
    row_nxt = c_end ? (r_end ? '0 : r_inc[BLK_W-1:0]) : r[BLK_W-1:0];
    rem_x   = w_r - DIM_W'({c, 2'b00});
    rem_y   = h_r - DIM_W'({r, 2'b00});
    bx      = XW'({c, 2'b00});
    by      = XW'({r, 2'b00});
  end

  always_comb begin
    q_job.color_half = in_data.color_half;
    q_job.alpha_half = in_data.alpha_half;
    q_job.fmt        = fmt_r;
    q_job.base_x     = bx[PIX_W-1:0];
    q_job.base_y     = by[PIX_W-1:0];
    q_job.ncm1       = (rem_x >= DIM_W'(4)) ? 2'd3 : 2'(rem_x - DIM_W'(1));
    q_job.nrm1       = (rem_y >= DIM_W'(4)) ? 2'd3 : 2'(rem_y - DIM_W'(1));
    q_job.last_img   = c_end && r_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dxt_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dxt_queue: short job queue between front and back
// Register-based FIFO of classified blocks.
// ----------------------------------------------------------------------------
module dxt_queue import dxt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output      logic push_ready,
  output      logic pop_valid,
  input  wire logic pop_ready,
  output      job_t pop_job
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_job    = mem_r[rd_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      if (do_pop)  rd_r <= (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dxt_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dxt_decode: two-stage palette builder
// Expands endpoints, then builds colour and alpha tables for each block.
// ----------------------------------------------------------------------------
module dxt_decode import dxt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_valid,
  output      logic job_ready,
  input  wire job_t job,
  output      logic blk_valid,
  input  wire logic blk_ready,
  output      blk_t blk
);

  pre_t pre_r, pre_nxt;
  blk_t blk_r, blk_nxt;
  logic pre_v_r, blk_v_r;
  logic pre_ready, ld_pre, ld_blk;
  logic [15:0] c0, c1;
  logic [7:0]  a0, a1;

  assign pre_ready = !blk_v_r || blk_ready;
  assign job_ready = !pre_v_r || pre_ready;
  assign ld_pre    = job_valid && job_ready;
  assign ld_blk    = pre_v_r && pre_ready;
  assign blk_valid = blk_v_r;
  assign blk       = blk_r;

  assign c0 = job.color_half[15:0];
  assign c1 = job.color_half[31:16];
  assign a0 = job.alpha_half[7:0];
  assign a1 = job.alpha_half[15:8];

  always_comb begin
    pre_nxt.job   = job;
    pre_nxt.er[0] = expand5(c0[15:11]);
    pre_nxt.eg[0] = expand6(c0[10:5]);
    pre_nxt.eb[0] = expand5(c0[4:0]);
    pre_nxt.er[1] = expand5(c1[15:11]);
    pre_nxt.eg[1] = expand6(c1[10:5]);
    pre_nxt.eb[1] = expand5(c1[4:0]);
    pre_nxt.punch = (job.fmt == FMT_DXT1) && (c0 <= c1);
    pre_nxt.agt   = a0 > a1;
    for (int i = 1; i <= 6; i++) begin
      if (a0 > a1) begin
        pre_nxt.num[i-1] = 11'(7 - i) * 11'(a0) + 11'(i) * 11'(a1);
      end else begin
        pre_nxt.num[i-1] = 11'((5 - i) & 7) * 11'(a0) + 11'(i) * 11'(a1);
      end
    end
  end

  always_comb begin
    blk_nxt.job   = pre_r.job;
    blk_nxt.punch = pre_r.punch;
    blk_nxt.cr[0] = pre_r.er[0];
    blk_nxt.cg[0] = pre_r.eg[0];
    blk_nxt.cb[0] = pre_r.eb[0];
    blk_nxt.cr[1] = pre_r.er[1];
    blk_nxt.cg[1] = pre_r.eg[1];
    blk_nxt.cb[1] = pre_r.eb[1];
    if (pre_r.punch) begin
      blk_nxt.cr[2] = 8'((10'(pre_r.er[0]) + 10'(pre_r.er[1])) >> 1);
      blk_nxt.cg[2] = 8'((10'(pre_r.eg[0]) + 10'(pre_r.eg[1])) >> 1);
      blk_nxt.cb[2] = 8'((10'(pre_r.eb[0]) + 10'(pre_r.eb[1])) >> 1);
      blk_nxt.cr[3] = '0;
      blk_nxt.cg[3] = '0;
      blk_nxt.cb[3] = '0;
    end else begin
      blk_nxt.cr[2] = div3({1'b0, pre_r.er[0], 1'b0} + 10'(pre_r.er[1]));
      blk_nxt.cg[2] = div3({1'b0, pre_r.eg[0], 1'b0} + 10'(pre_r.eg[1]));
      blk_nxt.cb[2] = div3({1'b0, pre_r.eb[0], 1'b0} + 10'(pre_r.eb[1]));
      blk_nxt.cr[3] = div3(10'(pre_r.er[0]) + {1'b0, pre_r.er[1], 1'b0});
      blk_nxt.cg[3] = div3(10'(pre_r.eg[0]) + {1'b0, pre_r.eg[1], 1'b0});
      blk_nxt.cb[3] = div3(10'(pre_r.eb[0]) + {1'b0, pre_r.eb[1], 1'b0});
    end
    blk_nxt.atab[0] = pre_r.job.alpha_half[7:0];
    blk_nxt.atab[1] = pre_r.job.alpha_half[15:8];
    for (int i = 1; i <= 6; i++) begin
      if (pre_r.agt)   blk_nxt.atab[i+1] = div7(pre_r.num[i-1]);
      else if (i <= 4) blk_nxt.atab[i+1] = div5(pre_r.num[i-1]);
      else if (i == 5) blk_nxt.atab[i+1] = 8'd0;
      else             blk_nxt.atab[i+1] = 8'd255;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_pre) pre_r <= pre_nxt;
    if (ld_blk) blk_r <= blk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
      blk_v_r <= 1'b0;
    end else begin
      if (job_ready) pre_v_r <= job_valid;
      if (pre_ready) blk_v_r <= pre_v_r;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dxt_emit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dxt_emit: texel sequencer and output register
// Emits a block's visible texels, one per cycle unless out_ready stalls.
// ----------------------------------------------------------------------------
module dxt_emit import dxt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic blk_valid,
  output      logic blk_ready,
  input  wire blk_t blk,
  output      logic out_valid,
  input  wire logic out_ready,
  output      out_t out_data
);

  blk_t       cur_r;
  logic       busy_r, out_valid_r;
  logic [1:0] cx_r, ry_r;
  out_t       out_r, tex;
  logic       adv, last, ld;
  logic [3:0] t;
  logic [1:0] idx;
  logic [2:0] code;
  logic [3:0] nib;
  logic [31:0] idx_word;
  logic [63:0] a_word;
  logic [47:0] code_word;

  assign adv       = busy_r && (!out_valid_r || out_ready);
  assign last      = (cx_r == cur_r.job.ncm1) && (ry_r == cur_r.job.nrm1);
  assign blk_ready = !busy_r || (adv && last);
  assign ld        = blk_valid && blk_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    t         = {ry_r, cx_r};
    idx_word  = cur_r.job.color_half[63:32] >> {t, 1'b0};
    idx       = idx_word[1:0];
    a_word    = cur_r.job.alpha_half >> {t, 2'b00};
    nib       = a_word[3:0];
    code_word = cur_r.job.alpha_half[63:16] >> ({1'b0, t, 1'b0} + 6'(t));
    code      = code_word[2:0];
    tex.red   = cur_r.cr[idx];
    tex.green = cur_r.cg[idx];
    tex.blue  = cur_r.cb[idx];
    case (cur_r.job.fmt)
      FMT_DXT3: tex.alpha = {nib, nib};
      FMT_DXT5: tex.alpha = cur_r.atab[code];
      default:  tex.alpha = (cur_r.punch && idx == 2'd3) ? 8'd0 : 8'd255;
    endcase
    tex.pixel_x       = cur_r.job.base_x + PIX_W'(cx_r);
    tex.pixel_y       = cur_r.job.base_y + PIX_W'(ry_r);
    tex.last_of_block = last;
    tex.last_of_image = last && cur_r.job.last_img;
  end

  always_ff @(posedge clk) begin
    if (ld)  cur_r <= blk;
    if (adv) out_r <= tex;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cx_r        <= '0;
      ry_r        <= '0;
    end else begin
      if (adv)            out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (ld) begin
        busy_r <= 1'b1;
        cx_r   <= '0;
        ry_r   <= '0;
      end else if (adv) begin
        if (last) busy_r <= 1'b0;
        if (cx_r == cur_r.job.ncm1) begin
          cx_r <= '0;
          ry_r <= ry_r + 2'd1;
        end else begin
          cx_r <= cx_r + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dxt_block_texture_decoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dxt_block_texture_decoder_unit: DXT1/DXT3/DXT5 block decompressor
// Turns compressed 4x4 blocks into cropped RGBA texels with coordinates.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one request per compressed block, in raster block order.
//   out_* : one request per visible texel, row by row within the block,
//           last_of_block on its final texel, last_of_image on the last
//           texel of the bottom-right block; block position then wraps.
//   cfg_* : format, width and height registers, always ready; write only
//           while the block holds no pending work.
//   Throughput: one texel per cycle while out_ready is high; the
//           single-texel output register and texel sequencer set this.
//   Path: the first texel of a block shows on out_valid after the block
//           passes the queue, two table stages, block and output registers.
//   Reset: synchronous on rst_n; config and control registers take their
//           defaults and the block counters return to the top-left block.
//   Stall: while out_ready is low the texel holds; the table stages and the
//           two-entry queue keep taking blocks until they fill.
// ----------------------------------------------------------------------------
module dxt_block_texture_decoder_unit import dxt_pkg::*; #(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire in_t                   in_data,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      out_t                  out_data
);

  logic q_ready, q_push, pop_valid, pop_ready, blk_valid, blk_ready;
  job_t q_job, pop_job;
  blk_t blk;

  assign cfg_ready = 1'b1;

  dxt_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_data, .q_ready, .q_push, .q_job
  );

  dxt_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_job(q_job), .push_ready(q_ready),
    .pop_valid, .pop_ready, .pop_job
  );

  dxt_decode u_decode (
    .clk, .rst_n, .job_valid(pop_valid), .job_ready(pop_ready), .job(pop_job),
    .blk_valid, .blk_ready, .blk
  );

  dxt_emit u_emit (
    .clk, .rst_n, .blk_valid, .blk_ready, .blk, .out_valid, .out_ready, .out_data
  );

endmodule
`default_nettype wire

// ----- hw/rtl/dxt_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dxt_chk: port-level checks for the block texture decoder
// Output channel behaviour over time, bound to the top level.
// ----------------------------------------------------------------------------
module dxt_chk import dxt_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled texel changed or dropped");

  a_img_in_blk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_image |-> out_data.last_of_block)
    else $error("image end without block end");

  a_blk_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_block |=> out_valid)
    else $error("gap inside a block");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("texel out of reset");

endmodule

bind dxt_block_texture_decoder_unit dxt_chk u_chk (.*);
`default_nettype wire
